// File: design/bilinear_image_resampler_unit_macros.svh
// assertion macros for the bilinear resampler
// expects i_clk and i_rst_n in the scope of each use
`ifndef BILINEAR_IMAGE_RESAMPLER_UNIT_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BIR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bir_pkg.sv
// shared types and constants of the bilinear resampler
// no dependencies
`timescale 1ns / 1ps

package bir_pkg;

    localparam int unsigned MAX_WIDTH_DEF     = 256;
    localparam int unsigned MAX_HEIGHT_DEF    = 256;
    localparam int unsigned FRACTION_BITS_DEF = 8;

    localparam int unsigned COORD_W    = 12;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned CHANNELS   = 3;
    localparam int unsigned PIXEL_W    = CHAN_W * CHANNELS;
    localparam int unsigned CFG_DIM_W  = 9;
    localparam int unsigned CFG_STEP_W = 16;
    localparam int unsigned PROD_W     = COORD_W + CFG_STEP_W;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned PADDR_W    = 4;

    localparam logic [CFG_DIM_W-1:0]  RST_SOURCE_WIDTH  = 9'd256;
    localparam logic [CFG_DIM_W-1:0]  RST_SOURCE_HEIGHT = 9'd256;
    localparam logic [CFG_STEP_W-1:0] RST_SOURCE_STEP   = 16'd256;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_SOURCE_STEP   = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_REQUEST = 1'b1
    } t_op;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]  source_width;
        logic [CFG_DIM_W-1:0]  source_height;
        logic [CFG_STEP_W-1:0] source_step;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic acc_en;
    } t_blend_ctl;

endpackage

// File: design/bir_req_if.sv
// input channel of the resampler: pixel writes and output pixel requests
// depends on bir_pkg
`timescale 1ns / 1ps

interface bir_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bir_pkg::COORD_W-1:0] column;
    logic [bir_pkg::COORD_W-1:0] row;
    logic [bir_pkg::CHAN_W-1:0]  red_in;
    logic [bir_pkg::CHAN_W-1:0]  green_in;
    logic [bir_pkg::CHAN_W-1:0]  blue_in;

    modport source (output valid, op, column, row, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, op, column, row, red_in, green_in, blue_in, output ready);
endinterface

// File: design/bir_res_if.sv
// output channel of the resampler: interpolated pixels
// depends on bir_pkg
`timescale 1ns / 1ps

interface bir_res_if;
    logic                       valid;
    logic                       ready;
    logic [bir_pkg::CHAN_W-1:0] red_out;
    logic [bir_pkg::CHAN_W-1:0] green_out;
    logic [bir_pkg::CHAN_W-1:0] blue_out;
    logic                       edge_clamped;

    modport source (output valid, red_out, green_out, blue_out, edge_clamped, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, edge_clamped, output ready);
endinterface

// File: design/bir_frame_mem.sv
// single-port synchronous frame memory with registered read data
// depends on bir_pkg for the pixel width
`timescale 1ns / 1ps

module bir_frame_mem #(
    parameter int unsigned DEPTH = bir_pkg::MAX_WIDTH_DEF * bir_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_addr,
    input  logic [bir_pkg::PIXEL_W-1:0] i_wdata,
    output logic [bir_pkg::PIXEL_W-1:0] o_rdata
);

    logic [bir_pkg::PIXEL_W-1:0] r_mem [DEPTH];
    logic [bir_pkg::PIXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bir_apb_regs.sv
// apb-style configuration registers: source width, height and step
// depends on bir_pkg
`timescale 1ns / 1ps

module bir_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bir_pkg::PADDR_W-1:0]    paddr,
    input  logic [bir_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bir_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output bir_pkg::t_cfg                  o_cfg
);

    bir_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // word index, byte lane bits are ignored
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= bir_pkg::RST_SOURCE_WIDTH;
            r_cfg.source_height <= bir_pkg::RST_SOURCE_HEIGHT;
            r_cfg.source_step   <= bir_pkg::RST_SOURCE_STEP;
        end else if (wr_en) begin
            unique case (reg_idx)
                bir_pkg::REG_SOURCE_WIDTH: begin
                    r_cfg.source_width <= pwdata[bir_pkg::CFG_DIM_W-1:0];
                end
                bir_pkg::REG_SOURCE_HEIGHT: begin
                    r_cfg.source_height <= pwdata[bir_pkg::CFG_DIM_W-1:0];
                end
                bir_pkg::REG_SOURCE_STEP: begin
                    r_cfg.source_step <= pwdata[bir_pkg::CFG_STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bir_pkg::REG_SOURCE_WIDTH:  prdata = bir_pkg::APB_DATA_W'(r_cfg.source_width);
            bir_pkg::REG_SOURCE_HEIGHT: prdata = bir_pkg::APB_DATA_W'(r_cfg.source_height);
            bir_pkg::REG_SOURCE_STEP:   prdata = bir_pkg::APB_DATA_W'(r_cfg.source_step);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/bir_blend.sv
// per-channel weighted accumulation of the four neighbour pixels
// depends on bir_pkg
`timescale 1ns / 1ps

module bir_blend #(
    parameter int unsigned FRACTION_BITS = bir_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  bir_pkg::t_blend_ctl         i_ctl,
    input  logic [2*FRACTION_BITS:0]    i_wt,
    input  logic [bir_pkg::PIXEL_W-1:0] i_pixel,
    output logic [bir_pkg::CHAN_W-1:0]  o_red,
    output logic [bir_pkg::CHAN_W-1:0]  o_green,
    output logic [bir_pkg::CHAN_W-1:0]  o_blue
);

    localparam int unsigned ACC_W = 2 * FRACTION_BITS + bir_pkg::CHAN_W;

    logic [ACC_W-1:0] r_acc [bir_pkg::CHANNELS];
    logic [ACC_W-1:0] n_acc [bir_pkg::CHANNELS];

    // channel 0 is red in the top byte
    always_comb begin
        for (int ch = 0; ch < bir_pkg::CHANNELS; ch++) begin
            n_acc[ch] = r_acc[ch] + ACC_W'(ACC_W'(i_wt)
                      * ACC_W'(i_pixel[bir_pkg::PIXEL_W-1-bir_pkg::CHAN_W*ch -: bir_pkg::CHAN_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < bir_pkg::CHANNELS; ch++) begin
            if (i_ctl.clear) begin
                r_acc[ch] <= '0;
            end else if (i_ctl.acc_en) begin
                r_acc[ch] <= n_acc[ch];
            end
        end
    end

    assign o_red   = r_acc[0][2*FRACTION_BITS +: bir_pkg::CHAN_W];
    assign o_green = r_acc[1][2*FRACTION_BITS +: bir_pkg::CHAN_W];
    assign o_blue  = r_acc[2][2*FRACTION_BITS +: bir_pkg::CHAN_W];

endmodule

// File: design/bilinear_image_resampler_unit.sv
// top level of the bilinear image resampler: sequencer, coordinate mapping, output register
// depends on bir_pkg, bir_req_if, bir_res_if, bir_frame_mem, bir_apb_regs, bir_blend
//
//   channel   direction  handshake            beat
//   i_req     in         valid / ready        op, column, row, red_in, green_in, blue_in
//   o_res     out        valid / ready        red_out, green_out, blue_out, edge_clamped
//   apb       in         psel / penable       paddr, pwdata -> prdata (pready tied high)
//
// a pixel write goes straight into the frame memory when it is accepted
// a request steps through accept, two passes through the shared coordinate multiplier,
// clamp, four reads of the single-port frame memory, one drain and one result load
// reset clears only control state; the frame memory is undefined until written
// a result waiting in o_res stalls only the next beat at i_req, not the one in progress
`timescale 1ns / 1ps

`include "bilinear_image_resampler_unit_macros.svh"

module bilinear_image_resampler_unit #(
    parameter int unsigned MAX_WIDTH     = bir_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT    = bir_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned FRACTION_BITS = bir_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bir_pkg::PADDR_W-1:0]    paddr,
    input  logic [bir_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bir_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    bir_req_if.sink                        i_req,
    bir_res_if.source                      o_res
);

    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned XW     = $clog2(MAX_WIDTH);
    localparam int unsigned YW     = $clog2(MAX_HEIGHT);
    localparam int unsigned F      = FRACTION_BITS;
    localparam int unsigned AX_W   = F + 1;
    localparam int unsigned WT_W   = 2 * F + 1;
    localparam int unsigned PROD_W = bir_pkg::PROD_W;
    // integer part of a mapped coordinate plus one bit for the +1 neighbour
    localparam int unsigned CMP_W  = PROD_W - F + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_CLAMP,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    bir_pkg::t_cfg cfg;

    // captured request coordinates and mapped products
    logic [bir_pkg::COORD_W-1:0] r_col;
    logic [bir_pkg::COORD_W-1:0] r_row;
    logic [PROD_W-1:0]           r_prod_x;
    logic [PROD_W-1:0]           r_prod_y;

    // clamped neighbour coordinates and fractions
    logic [XW-1:0] r_x0;
    logic [XW-1:0] r_x1;
    logic [YW-1:0] r_y0;
    logic [YW-1:0] r_y1;
    logic [F-1:0]  r_fx;
    logic [F-1:0]  r_fy;
    logic          r_clamped;

    // read sequencing
    logic [1:0]      r_k;
    logic            r_acc_en;
    logic [WT_W-1:0] r_wt;

    // output register
    logic                       r_out_valid;
    logic [bir_pkg::CHAN_W-1:0] r_red;
    logic [bir_pkg::CHAN_W-1:0] r_green;
    logic [bir_pkg::CHAN_W-1:0] r_blue;
    logic                       r_edge;

    // combinational helpers
    logic                        req_fire;
    logic                        wr_in_range;
    logic                        mem_en;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [bir_pkg::PIXEL_W-1:0] wr_pixel;
    logic [bir_pkg::PIXEL_W-1:0] rd_pixel;
    logic [bir_pkg::COORD_W-1:0] mul_a;
    logic [PROD_W-1:0]           mul_p;
    logic [CMP_W-1:0]            w_bound;
    logic [CMP_W-1:0]            h_bound;
    logic [CMP_W-1:0]            last_x;
    logic [CMP_W-1:0]            last_y;
    logic [CMP_W-1:0]            px0;
    logic [CMP_W-1:0]            px1;
    logic [CMP_W-1:0]            py0;
    logic [CMP_W-1:0]            py1;
    logic [CMP_W-1:0]            cx0;
    logic [CMP_W-1:0]            cx1;
    logic [CMP_W-1:0]            cy0;
    logic [CMP_W-1:0]            cy1;
    logic                        any_clamp;
    logic [XW-1:0]               rd_x;
    logic [YW-1:0]               rd_y;
    logic [AX_W-1:0]             ax;
    logic [AX_W-1:0]             ay;
    logic [bir_pkg::CHAN_W-1:0]  blend_red;
    logic [bir_pkg::CHAN_W-1:0]  blend_green;
    logic [bir_pkg::CHAN_W-1:0]  blend_blue;
    bir_pkg::t_blend_ctl         blend_ctl;

    bir_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // new beats only between requests and with the result slot free or draining
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign req_fire    = i_req.valid && i_req.ready;

    // writes outside the frame are dropped
    assign wr_in_range = ((bir_pkg::COORD_W + 1)'(i_req.column) < (bir_pkg::COORD_W + 1)'(MAX_WIDTH))
                      && ((bir_pkg::COORD_W + 1)'(i_req.row) < (bir_pkg::COORD_W + 1)'(MAX_HEIGHT));
    assign wr_addr  = ADDR_W'(ADDR_W'(i_req.row[YW-1:0]) * ADDR_W'(MAX_WIDTH))
                    + ADDR_W'(i_req.column[XW-1:0]);
    assign wr_pixel = {i_req.red_in, i_req.green_in, i_req.blue_in};

    // neighbour order: top-left, top-right, bottom-left, bottom-right
    assign rd_x    = r_k[0] ? r_x1 : r_x0;
    assign rd_y    = r_k[1] ? r_y1 : r_y0;
    assign rd_addr = ADDR_W'(ADDR_W'(rd_y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(rd_x);

    // writes only happen in idle and reads only in the read state, so the port never clashes
    assign mem_we   = req_fire && (i_req.op == bir_pkg::OP_WRITE) && wr_in_range;
    assign mem_en   = mem_we || (r_state == S_READ);
    assign mem_addr = mem_we ? wr_addr : rd_addr;

    bir_frame_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (wr_pixel),
        .o_rdata (rd_pixel)
    );

    // one multiplier shared by the column and row mappings
    assign mul_a = (r_state == S_MUL_X) ? r_col : r_row;
    assign mul_p = PROD_W'(PROD_W'(mul_a) * PROD_W'(cfg.source_step));

    // effective frame size: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (cfg.source_width == '0) begin
            w_bound = CMP_W'(1);
        end else if (CMP_W'(cfg.source_width) > CMP_W'(MAX_WIDTH)) begin
            w_bound = CMP_W'(MAX_WIDTH);
        end else begin
            w_bound = CMP_W'(cfg.source_width);
        end
        if (cfg.source_height == '0) begin
            h_bound = CMP_W'(1);
        end else if (CMP_W'(cfg.source_height) > CMP_W'(MAX_HEIGHT)) begin
            h_bound = CMP_W'(MAX_HEIGHT);
        end else begin
            h_bound = CMP_W'(cfg.source_height);
        end
    end

    assign last_x = w_bound - CMP_W'(1);
    assign last_y = h_bound - CMP_W'(1);

    // integer parts and their right/lower neighbours, clamped to the last column/row
    assign px0 = CMP_W'(r_prod_x[PROD_W-1:F]);
    assign px1 = px0 + CMP_W'(1);
    assign py0 = CMP_W'(r_prod_y[PROD_W-1:F]);
    assign py1 = py0 + CMP_W'(1);
    assign cx0 = (px0 > last_x) ? last_x : px0;
    assign cx1 = (px1 > last_x) ? last_x : px1;
    assign cy0 = (py0 > last_y) ? last_y : py0;
    assign cy1 = (py1 > last_y) ? last_y : py1;
    assign any_clamp = (px0 > last_x) || (px1 > last_x) || (py0 > last_y) || (py1 > last_y);

    // weight factors for the neighbour being read: fraction towards it, else its complement
    assign ax = r_k[0] ? AX_W'(r_fx) : ((AX_W'(1) << F) - AX_W'(r_fx));
    assign ay = r_k[1] ? AX_W'(r_fy) : ((AX_W'(1) << F) - AX_W'(r_fy));

    // accumulators clear before the first read and add one neighbour per returned word
    assign blend_ctl.clear  = (r_state == S_CLAMP);
    assign blend_ctl.acc_en = r_acc_en;

    bir_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_ctl   (blend_ctl),
        .i_wt    (r_wt),
        .i_pixel (rd_pixel),
        .o_red   (blend_red),
        .o_green (blend_green),
        .o_blue  (blend_blue)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc_en    <= 1'b0;
            r_k         <= '0;
        end else begin
            // the slot is loaded in the done state, so it only drains outside it
            if (o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            // the word read in this cycle is summed in the next one
            r_acc_en <= (r_state == S_READ);
            r_wt     <= WT_W'(ax) * WT_W'(ay);

            unique case (r_state)
                S_IDLE: begin
                    if (req_fire && (i_req.op == bir_pkg::OP_REQUEST)) begin
                        r_col   <= i_req.column;
                        r_row   <= i_req.row;
                        r_state <= S_MUL_X;
                    end
                end
                S_MUL_X: begin
                    r_prod_x <= mul_p;
                    r_state  <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_prod_y <= mul_p;
                    r_state  <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_x0      <= cx0[XW-1:0];
                    r_x1      <= cx1[XW-1:0];
                    r_y0      <= cy0[YW-1:0];
                    r_y1      <= cy1[YW-1:0];
                    r_fx      <= r_prod_x[F-1:0];
                    r_fy      <= r_prod_y[F-1:0];
                    r_clamped <= any_clamp;
                    r_k       <= '0;
                    r_state   <= S_READ;
                end
                S_READ: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_red       <= blend_red;
                    r_green     <= blend_green;
                    r_blue      <= blend_blue;
                    r_edge      <= r_clamped;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.red_out      = r_red;
    assign o_res.green_out    = r_green;
    assign o_res.blue_out     = r_blue;
    assign o_res.edge_clamped = r_edge;

    // a request beat starts the mapping straight away
    `BIR_ASSERT_NEXT(a_req_starts_map, req_fire && (i_req.op == bir_pkg::OP_REQUEST), r_state == S_MUL_X, "request beat did not start the coordinate mapping")
    // a pixel write leaves the sequencer free for the next beat
    `BIR_ASSERT_NEXT(a_write_stays_idle, req_fire && (i_req.op == bir_pkg::OP_WRITE), r_state == S_IDLE, "pixel write left the sequencer busy")
    // the frame memory is written only between requests
    `BIR_ASSERT_NOW(a_write_only_idle, mem_we, r_state == S_IDLE, "frame memory written during a request")
    // the result slot is free when a blend finishes
    `BIR_ASSERT_NOW(a_slot_free, r_state == S_DONE, !r_out_valid, "result slot still occupied at blend end")

endmodule
